// File: rtl/core/aawc_pkg.sv
// aawc_pkg: shared types, constants and codes for the arena allocator core
// no dependencies
package aawc_pkg;

    localparam int MAX_BUFFERS = 16;
    localparam int OFFSET_BITS = 16;
    localparam int IDX_BITS = $clog2(MAX_BUFFERS);
    localparam int CNT_BITS = $clog2(MAX_BUFFERS + 1);
    localparam int VAL_BITS = 17;
    localparam int WIDE_BITS = 19;
    localparam logic [VAL_BITS-1:0] ARENA_LIMIT = VAL_BITS'(1 << OFFSET_BITS);

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE = 2'd1;
    localparam logic [1:0] KIND_STATIC = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OOM = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic RK_DONE = 1'b0;
    localparam logic RK_MOVE = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [15:0] buffer_id;
        logic [16:0] request_bytes;
        logic [2:0] align_log2;
    } t_in_item;

    typedef struct packed {
        logic result_kind;
        logic [1:0] status;
        logic [16:0] offset;
        logic [16:0] move_source;
        logic [16:0] move_bytes;
        logic last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CMP_READ,
        S_CMP_STEP,
        S_ALLOC,
        S_SEARCH_READ,
        S_SEARCH_STEP,
        S_SHIFT_READ,
        S_SHIFT_STEP,
        S_STATIC,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic init;
        logic latch_in;
        logic clr_idx;
        logic inc_idx;
        logic rd_idx;
        logic rd_next;
        logic cmp_start;
        logic cmp_step;
        logic cmp_done;
        logic do_alloc;
        logic do_free;
        logic shift_write;
        logic do_static;
        logic out_load;
        logic out_clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic pending;
        logic idx_end;
        logic shift_end;
        logic id_match;
        logic move_needed;
        logic out_valid;
    } t_stat;

endpackage

// File: rtl/core/aawc_ctrl.sv
// aawc_ctrl: sequencer for allocate, free, static and compaction walks
// depends on aawc_pkg
module aawc_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_cfg_valid,
    input  aawc_pkg::t_stat i_stat,
    output logic o_in_ready,
    output logic o_cfg_ready,
    output aawc_pkg::t_cmd o_cmd
);

    aawc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aawc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            aawc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = aawc_pkg::S_DISPATCH;
            end
            aawc_pkg::S_DISPATCH: begin
                case (i_stat.kind)
                    aawc_pkg::KIND_ALLOC:
                        n_state = i_stat.pending ? aawc_pkg::S_CMP_READ : aawc_pkg::S_ALLOC;
                    aawc_pkg::KIND_FREE: n_state = aawc_pkg::S_SEARCH_READ;
                    aawc_pkg::KIND_STATIC: n_state = aawc_pkg::S_STATIC;
                    default: n_state = aawc_pkg::S_IDLE;
                endcase
            end
            aawc_pkg::S_CMP_READ: begin
                n_state = i_stat.idx_end ? aawc_pkg::S_ALLOC : aawc_pkg::S_CMP_STEP;
            end
            aawc_pkg::S_CMP_STEP: begin
                if (!(i_stat.move_needed && i_stat.out_valid)) n_state = aawc_pkg::S_CMP_READ;
            end
            aawc_pkg::S_ALLOC: begin
                if (!i_stat.out_valid) n_state = aawc_pkg::S_EMIT;
            end
            aawc_pkg::S_SEARCH_READ: begin
                n_state = i_stat.idx_end ? aawc_pkg::S_EMIT : aawc_pkg::S_SEARCH_STEP;
            end
            aawc_pkg::S_SEARCH_STEP: begin
                n_state = i_stat.id_match ? aawc_pkg::S_SHIFT_READ : aawc_pkg::S_SEARCH_READ;
            end
            aawc_pkg::S_SHIFT_READ: begin
                n_state = i_stat.shift_end ? aawc_pkg::S_EMIT : aawc_pkg::S_SHIFT_STEP;
            end
            aawc_pkg::S_SHIFT_STEP: n_state = aawc_pkg::S_SHIFT_READ;
            aawc_pkg::S_STATIC: n_state = aawc_pkg::S_EMIT;
            aawc_pkg::S_EMIT: begin
                if (!i_stat.out_valid) n_state = aawc_pkg::S_IDLE;
            end
            default: n_state = aawc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            aawc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cfg_ready = !i_in_valid;
                o_cmd.init = i_cfg_valid && !i_in_valid;
                o_cmd.latch_in = i_in_valid;
                o_cmd.clr_idx = 1'b1;
            end
            aawc_pkg::S_DISPATCH: begin
                o_cmd.rd_idx = 1'b1;
                o_cmd.cmp_start = (i_stat.kind == aawc_pkg::KIND_ALLOC) && i_stat.pending;
            end
            aawc_pkg::S_CMP_READ: begin
                o_cmd.cmp_done = i_stat.idx_end;
            end
            aawc_pkg::S_CMP_STEP: begin
                if (!(i_stat.move_needed && i_stat.out_valid)) begin
                    o_cmd.cmp_step = 1'b1;
                    o_cmd.out_load = i_stat.move_needed;
                    o_cmd.inc_idx = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end
            end
            aawc_pkg::S_ALLOC: o_cmd.do_alloc = !i_stat.out_valid;
            aawc_pkg::S_SEARCH_READ: begin
                o_cmd.out_clear = i_stat.idx_end;
            end
            aawc_pkg::S_SEARCH_STEP: begin
                if (i_stat.id_match) begin
                    o_cmd.do_free = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end
            end
            aawc_pkg::S_SHIFT_READ: o_cmd.rd_next = 1'b1;
            aawc_pkg::S_SHIFT_STEP: begin
                o_cmd.shift_write = 1'b1;
                o_cmd.inc_idx = 1'b1;
                o_cmd.rd_next = 1'b1;
            end
            aawc_pkg::S_STATIC: o_cmd.do_static = 1'b1;
            aawc_pkg::S_EMIT: ;
            default: ;
        endcase
    end

endmodule

// File: rtl/core/aawc_dp.sv
// aawc_dp: entry table memory, offset registers, alignment math, result register
// depends on aawc_pkg
module aawc_dp (
    input  logic i_clk,
    input  logic i_rst_n,
    input  aawc_pkg::t_in_item i_in,
    input  logic [16:0] i_cfg_data,
    input  logic i_out_ready,
    input  aawc_pkg::t_cmd i_cmd,
    output aawc_pkg::t_stat o_stat,
    output logic o_out_valid,
    output aawc_pkg::t_out_item o_out
);

    localparam int IB = aawc_pkg::IDX_BITS;
    localparam int CB = aawc_pkg::CNT_BITS;
    localparam int VB = aawc_pkg::VAL_BITS;
    localparam int WB = aawc_pkg::WIDE_BITS;

    typedef struct packed {
        logic [15:0] id;
        logic [VB-1:0] offset;
        logic [VB-1:0] length;
        logic [2:0] align;
    } t_entry;

    t_entry r_mem [aawc_pkg::MAX_BUFFERS];
    t_entry r_rd;
    t_entry n_wr;
    logic n_we;
    logic [IB-1:0] n_waddr;
    logic [IB-1:0] n_raddr;

    aawc_pkg::t_in_item r_in;
    logic [CB-1:0] r_count;
    logic [VB-1:0] r_front;
    logic [VB-1:0] r_back;
    logic r_pending;
    logic [CB-1:0] r_idx;
    logic [VB-1:0] r_cfront;
    logic r_out_valid;
    aawc_pkg::t_out_item r_out;

    logic [WB-1:0] w_mask_in;
    logic [WB-1:0] w_mask_rd;
    logic [WB-1:0] w_start;
    logic [WB-1:0] w_dst;
    logic [WB-1:0] w_sdiff;
    logic [WB-1:0] w_sstart;
    logic [CB-1:0] w_idx_next;
    logic w_hit;
    logic w_oom;
    logic w_soom;
    logic w_move_free;

    assign w_mask_in = WB'((1 << r_in.align_log2) - 1);
    assign w_mask_rd = WB'((1 << r_rd.align) - 1);
    assign w_start = (WB'(r_front) + w_mask_in) & ~w_mask_in;
    assign w_dst = (WB'(r_cfront) + w_mask_rd) & ~w_mask_rd;
    assign w_oom = (w_start + WB'(r_in.request_bytes)) > WB'(r_back);
    assign w_sdiff = WB'(r_back) - WB'(r_in.request_bytes);
    assign w_sstart = w_sdiff & ~w_mask_in;
    assign w_soom = (r_in.request_bytes > r_back) || (w_sstart < WB'(r_front));
    assign w_idx_next = r_idx + CB'(1);
    assign w_hit = (r_rd.id == r_in.buffer_id);
    assign w_move_free = !r_out_valid || i_out_ready;

    assign o_stat.kind = r_in.kind;
    assign o_stat.pending = r_pending;
    assign o_stat.idx_end = (r_idx >= r_count);
    assign o_stat.shift_end = (r_idx >= r_count);
    assign o_stat.id_match = w_hit;
    assign o_stat.move_needed = (w_dst[VB-1:0] != r_rd.offset);
    assign o_stat.out_valid = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    always_comb begin
        n_raddr = r_idx[IB-1:0];
        if (i_cmd.rd_next) n_raddr = w_idx_next[IB-1:0];
        if (i_cmd.clr_idx) n_raddr = '0;
        n_we = 1'b0;
        n_waddr = r_idx[IB-1:0];
        n_wr = r_rd;
        if (i_cmd.cmp_step) begin
            n_we = 1'b1;
            n_wr.offset = w_dst[VB-1:0];
        end
        if (i_cmd.do_alloc && !(r_count >= CB'(aawc_pkg::MAX_BUFFERS)) && !w_oom) begin
            n_we = 1'b1;
            n_waddr = r_count[IB-1:0];
            n_wr.id = r_in.buffer_id;
            n_wr.offset = w_start[VB-1:0];
            n_wr.length = r_in.request_bytes;
            n_wr.align = r_in.align_log2;
        end
        if (i_cmd.shift_write) begin
            n_we = 1'b1;
        end
    end

    // the shift writes entry idx with the contents read from idx+1
    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wr;
        r_rd <= r_mem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) r_in <= i_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_front <= '0;
            r_back <= aawc_pkg::ARENA_LIMIT;
            r_pending <= 1'b0;
            r_idx <= '0;
            r_cfront <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.init) begin
                r_back <= (i_cfg_data > aawc_pkg::ARENA_LIMIT) ? aawc_pkg::ARENA_LIMIT
                                                                : i_cfg_data;
                r_count <= '0;
                r_front <= '0;
                r_pending <= 1'b0;
            end
            if (i_cmd.clr_idx) r_idx <= '0;
            if (i_cmd.inc_idx) r_idx <= w_idx_next;
            if (i_cmd.cmp_start) r_cfront <= '0;
            if (i_cmd.cmp_step) r_cfront <= VB'(w_dst + WB'(r_rd.length));
            if (i_cmd.cmp_done) begin
                r_front <= r_cfront;
                r_pending <= 1'b0;
            end
            if (i_cmd.out_load && w_move_free) begin
                r_out_valid <= 1'b1;
                r_out.result_kind <= aawc_pkg::RK_MOVE;
                r_out.status <= aawc_pkg::ST_OK;
                r_out.offset <= w_dst[VB-1:0];
                r_out.move_source <= r_rd.offset;
                r_out.move_bytes <= r_rd.length;
                r_out.last <= 1'b0;
            end
            if (i_cmd.do_alloc || i_cmd.do_static || i_cmd.do_free || i_cmd.out_clear) begin
                r_out_valid <= 1'b1;
                r_out.result_kind <= aawc_pkg::RK_DONE;
                r_out.status <= aawc_pkg::ST_OK;
                r_out.offset <= '0;
                r_out.move_source <= '0;
                r_out.move_bytes <= '0;
                r_out.last <= 1'b1;
            end
            if (i_cmd.out_clear) r_out.status <= aawc_pkg::ST_NOTFOUND;
            if (i_cmd.do_free) begin
                r_out.offset <= r_rd.offset;
                r_count <= r_count - CB'(1);
                r_pending <= 1'b1;
            end
            if (i_cmd.do_alloc) begin
                if (r_count >= CB'(aawc_pkg::MAX_BUFFERS)) begin
                    r_out.status <= aawc_pkg::ST_FULL;
                end else if (w_oom) begin
                    r_out.status <= aawc_pkg::ST_OOM;
                end else begin
                    r_out.offset <= w_start[VB-1:0];
                    r_count <= r_count + CB'(1);
                    r_front <= VB'(w_start + WB'(r_in.request_bytes));
                end
            end
            if (i_cmd.do_static) begin
                if (w_soom) begin
                    r_out.status <= aawc_pkg::ST_OOM;
                end else begin
                    r_out.offset <= w_sstart[VB-1:0];
                    r_back <= w_sstart[VB-1:0];
                end
            end
        end
    end

endmodule

// File: rtl/core/arena_allocator_with_compaction_core.sv
// static or compaction-free allocation: dispatch, then the state that registers the result
// compaction steps through each live entry first; free searches, then shifts later entries down
// one item at a time: a new item is accepted only in idle, after the last result is taken
// all results leave through one output register; output stalls hold the walk
// synchronous active-low reset: empty table, arena 65536 bytes
// depends on aawc_pkg, aawc_ctrl, aawc_dp
module arena_allocator_with_compaction_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  aawc_pkg::t_in_item i_in_item,
    output logic o_out_valid,
    input  logic i_out_ready,
    output aawc_pkg::t_out_item o_out_item,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    aawc_pkg::t_cmd w_cmd;
    aawc_pkg::t_stat w_stat;

    aawc_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_cfg_valid(i_cfg_valid),
        .i_stat(w_stat),
        .o_in_ready(o_in_ready),
        .o_cfg_ready(o_cfg_ready),
        .o_cmd(w_cmd)
    );

    aawc_dp u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(i_in_item),
        .i_cfg_data(i_cfg_data),
        .i_out_ready(i_out_ready),
        .i_cmd(w_cmd),
        .o_stat(w_stat),
        .o_out_valid(o_out_valid),
        .o_out(o_out_item)
    );

endmodule
